### design/verlet_particle_integrator_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the particle integrator
// Shared forms for concurrent checks clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef VERLET_PARTICLE_INTEGRATOR_UNIT_DEFINES_SVH
`define VERLET_PARTICLE_INTEGRATOR_UNIT_DEFINES_SVH

// Check the consequent in the same cycle as the antecedent
`define VPI_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check the consequent in the cycle after the antecedent
`define VPI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/vpi_pkg.sv
// ----------------------------------------------------------------------------
// vpi_pkg
// Types, codes, constants and fixed-point helpers of the particle integrator.
// ----------------------------------------------------------------------------
package vpi_pkg;

	// Default table depth
	localparam int PARTICLES_DEF = 2;

	// Request function codes
	localparam logic [1:0] FUNC_STEP     = 2'd0;
	localparam logic [1:0] FUNC_LOAD_POS = 2'd1;
	localparam logic [1:0] FUNC_LOAD_VEL = 2'd2;
	localparam logic [1:0] FUNC_LOAD_ACC = 2'd3;

	// Configuration register indexes
	localparam logic [1:0] REG_TIME_STEP   = 2'd0;
	localparam logic [1:0] REG_ROOM_LENGTH = 2'd1;
	localparam logic [1:0] REG_ROOM_WIDTH  = 2'd2;

	// Configuration reset values
	localparam logic [15:0] TIME_STEP_RESET   = 16'd66;
	localparam logic [14:0] ROOM_LENGTH_RESET = 15'd10;
	localparam logic [14:0] ROOM_WIDTH_RESET  = 15'd6;

	// Angle limits in Q16.16
	localparam logic signed [31:0] PI_Q     = 32'sd205887;
	localparam logic signed [31:0] TWO_PI_Q = 32'sd411775;

	// Working width for saturation and wall arithmetic
	localparam int WIDE_W = 40;

	typedef logic [31:0] word_t;
	typedef word_t [2:0] vec3_t;           // [0] x, [1] y, [2] angle
	typedef logic signed [WIDE_W-1:0] wide_t;

	typedef struct packed {
		vec3_t acc;
		vec3_t vel;
		vec3_t pos;
	} pstate_t;

	// Clamp a wide signed value to the signed 32-bit range
	function automatic word_t sat32(input wide_t v);
		wide_t hi;
		wide_t lo;
		hi = wide_t'(32'sh7fffffff);
		lo = wide_t'(32'sh80000000);
		if (v > hi) begin
			return 32'h7fffffff;
		end else if (v < lo) begin
			return 32'h80000000;
		end
		return v[31:0];
	endfunction

	// Negate with saturation of the most negative value
	function automatic word_t neg_sat(input word_t v);
		return sat32(-wide_t'($signed(v)));
	endfunction

endpackage

### design/verlet_particle_integrator_unit.sv
// ----------------------------------------------------------------------------
// verlet_particle_integrator_unit
// Velocity-Verlet integrator over a table of particles held in one memory.
// ----------------------------------------------------------------------------
// Each request reads one particle's full state word (position, angle,
// velocity, acceleration) from a single synchronous memory, runs it through
// a multiply stage, two add stages and a wall/angle-wrap stage, and writes
// the word back as the result is registered. The next request is accepted
// in the cycle after the result is registered, so the block takes no new
// request before the last one's result is registered. This is set by the
// read-modify-write of the state memory through the multiply and add chain.
// After reset the block clears the memory, one particle per cycle, before it
// accepts its first request; configuration writes are taken at any time.
module verlet_particle_integrator_unit
	import vpi_pkg::*;
#(
	parameter int PARTICLES = PARTICLES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration write port
	input  logic               cfg_wr_en,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	// request channel
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         func,
	input  logic [9:0]         particle,
	input  logic signed [31:0] value_x,
	input  logic signed [31:0] value_y,
	input  logic signed [31:0] value_a,
	// result channel
	output logic               out_valid,
	input  logic               out_ready,
	output logic [9:0]         particle_out,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [31:0] heading,
	output logic signed [31:0] vel_x_out,
	output logic signed [31:0] vel_y_out,
	output logic signed [31:0] vel_a_out,
	output logic               wrap_fault
);

	localparam int PIDX_W = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_MUL   = 3'd2;
	localparam logic [2:0] ST_ADD1  = 3'd3;
	localparam logic [2:0] ST_ADD2  = 3'd4;
	localparam logic [2:0] ST_FIN   = 3'd5;

	// Control
	logic [2:0]        state_q;
	logic [PIDX_W-1:0] clr_q;
	logic              in_fire;
	logic              fin_go;

	// Configuration
	logic [15:0] time_step_q;
	logic [14:0] room_length_q;
	logic [14:0] room_width_q;
	logic [31:0] dt2_q;

	// Request held for the whole pass
	logic [1:0] func_q;
	logic [9:0] pidx_q;
	logic       oor_q;
	vec3_t      val_q;

	// State memory and its read port
	pstate_t           state_mem_q [PARTICLES];
	pstate_t           rd_s1;
	logic              mem_we;
	logic [PIDX_W-1:0] mem_waddr;
	pstate_t           mem_wdata;

	// Lane pipeline
	logic signed [48:0] mul_v [3];
	logic signed [64:0] mul_a [3];
	logic signed [32:0] force_sum [3];
	logic signed [49:0] mul_i [3];
	logic signed [49:0] sum_s [3];
	logic signed [49:0] sum_i [3];
	logic signed [34:0] new_p [3];
	word_t              vel_plain [3];
	word_t              vel_refl [3];

	logic signed [48:0] pv_s2 [3];
	logic signed [64:0] pa_s2 [3];
	logic signed [49:0] pi_s2 [3];
	logic signed [49:0] s_s3 [3];
	logic signed [32:0] inc_s3 [3];
	logic signed [34:0] pn_s4 [3];
	word_t              vp_s4 [3];
	word_t              vr_s4 [3];

	// Final stage
	vec3_t   fin_pos;
	vec3_t   fin_vel;
	logic    fin_fault;
	pstate_t wr_word;

	// Result register
	logic       out_valid_q;
	logic [9:0] particle_out_q;
	vec3_t      out_pos_q;
	vec3_t      out_vel_q;
	logic       out_fault_q;

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign fin_go   = (state_q == ST_FIN) && (!out_valid_q || out_ready);

	// Hold configuration registers and the squared step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q   <= TIME_STEP_RESET;
			room_length_q <= ROOM_LENGTH_RESET;
			room_width_q  <= ROOM_WIDTH_RESET;
			dt2_q         <= 32'(TIME_STEP_RESET * TIME_STEP_RESET);
		end else begin
			dt2_q <= time_step_q * time_step_q;
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_TIME_STEP:   time_step_q   <= cfg_data;
					REG_ROOM_LENGTH: room_length_q <= cfg_data[14:0];
					REG_ROOM_WIDTH:  room_width_q  <= cfg_data[14:0];
					default: ;
				endcase
			end
		end
	end

	// Advance the sequencer, run the clearing pass, track the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					if (clr_q == PIDX_W'(PARTICLES - 1)) begin
						state_q <= ST_IDLE;
					end else begin
						clr_q <= clr_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL:  state_q <= ST_ADD1;
				ST_ADD1: state_q <= ST_ADD2;
				ST_ADD2: state_q <= ST_FIN;
				ST_FIN: begin
					if (fin_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Capture the request
	always_ff @(posedge clk) begin
		if (in_fire) begin
			func_q <= func;
			pidx_q <= particle;
			oor_q  <= (int'(particle) >= PARTICLES);
			val_q  <= {value_a, value_y, value_x};
		end
	end

	// Select the memory write: clearing pass or write-back
	always_comb begin
		mem_we    = (state_q == ST_CLEAR) || (fin_go && !oor_q);
		mem_waddr = (state_q == ST_CLEAR) ? clr_q : pidx_q[PIDX_W-1:0];
		mem_wdata = (state_q == ST_CLEAR) ? '0 : wr_word;
	end

	// State memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			state_mem_q[mem_waddr] <= mem_wdata;
		end
		if (in_fire) begin
			rd_s1 <= state_mem_q[particle[PIDX_W-1:0]];
		end
	end

	// Lane arithmetic for x, y and angle
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			mul_v[j]     = $signed(rd_s1.vel[j]) * $signed({1'b0, time_step_q});
			mul_a[j]     = $signed(rd_s1.acc[j]) * $signed({1'b0, dt2_q});
			force_sum[j] = 33'($signed(rd_s1.acc[j])) + 33'($signed(val_q[j]));
			mul_i[j]     = force_sum[j] * $signed({1'b0, time_step_q});
			// v*dt + floor(acc*dt*dt/2) in Q.32, plus half an output lsb
			sum_s[j]     = 50'(pv_s2[j]) + 50'($signed(pa_s2[j][64:17])) + 50'sd32768;
			sum_i[j]     = pi_s2[j] + 50'sd65536;
			new_p[j]     = 35'($signed(rd_s1.pos[j])) + 35'($signed(s_s3[j][49:16]));
			vel_plain[j] = sat32(wide_t'($signed(rd_s1.vel[j])) + wide_t'(inc_s3[j]));
			vel_refl[j]  = sat32(wide_t'($signed(neg_sat(rd_s1.vel[j]))) + wide_t'(inc_s3[j]));
		end
	end

	// Step the lane pipeline
	always_ff @(posedge clk) begin
		case (state_q)
			ST_MUL: begin
				for (int j = 0; j < 3; j++) begin
					pv_s2[j] <= mul_v[j];
					pa_s2[j] <= mul_a[j];
					pi_s2[j] <= mul_i[j];
				end
			end
			ST_ADD1: begin
				for (int j = 0; j < 3; j++) begin
					s_s3[j]   <= sum_s[j];
					inc_s3[j] <= sum_i[j][49:17];
				end
			end
			ST_ADD2: begin
				for (int j = 0; j < 3; j++) begin
					pn_s4[j] <= new_p[j];
					vp_s4[j] <= vel_plain[j];
					vr_s4[j] <= vel_refl[j];
				end
			end
			default: ;
		endcase
	end

	// Reflect at the walls, wrap the angle once
	always_comb begin
		wide_t pw;
		wide_t bound_w;
		wide_t refl;
		wide_t ang;
		logic  hit;
		for (int j = 0; j < 2; j++) begin
			pw      = wide_t'(pn_s4[j]);
			bound_w = (j == 0) ? wide_t'({room_length_q, 16'h0000})
			                   : wide_t'({room_width_q, 16'h0000});
			hit     = 1'b0;
			refl    = pw;
			if (pw[WIDE_W-1]) begin
				refl = -pw;
				hit  = 1'b1;
			end else if (pw > bound_w) begin
				refl = (bound_w <<< 1) - pw;
				hit  = 1'b1;
			end
			fin_pos[j] = sat32(refl);
			fin_vel[j] = hit ? vr_s4[j] : vp_s4[j];
		end
		ang = wide_t'(pn_s4[2]);
		if (ang > wide_t'(PI_Q)) begin
			ang = ang - wide_t'(TWO_PI_Q);
		end else if (ang < -wide_t'(PI_Q)) begin
			ang = ang + wide_t'(TWO_PI_Q);
		end
		fin_fault  = (ang > wide_t'(PI_Q)) || (ang < -wide_t'(PI_Q));
		fin_pos[2] = sat32(ang);
		fin_vel[2] = vp_s4[2];
	end

	// Build the write-back word
	always_comb begin
		wr_word = rd_s1;
		case (func_q)
			FUNC_STEP: begin
				wr_word.pos = fin_pos;
				wr_word.vel = fin_vel;
				wr_word.acc = val_q;
			end
			FUNC_LOAD_POS: wr_word.pos = val_q;
			FUNC_LOAD_VEL: wr_word.vel = val_q;
			FUNC_LOAD_ACC: wr_word.acc = val_q;
			default:       wr_word = rd_s1;
		endcase
	end

	// Load the result register; drop state fields for an absent particle
	always_ff @(posedge clk) begin
		if (fin_go) begin
			particle_out_q <= pidx_q;
			out_pos_q      <= oor_q ? '0 : wr_word.pos;
			out_vel_q      <= oor_q ? '0 : wr_word.vel;
			out_fault_q    <= !oor_q && (func_q == FUNC_STEP) && fin_fault;
		end
	end

	assign out_valid    = out_valid_q;
	assign particle_out = particle_out_q;
	assign pos_x        = out_pos_q[0];
	assign pos_y        = out_pos_q[1];
	assign heading      = out_pos_q[2];
	assign vel_x_out    = out_vel_q[0];
	assign vel_y_out    = out_vel_q[1];
	assign vel_a_out    = out_vel_q[2];
	assign wrap_fault   = out_fault_q;

endmodule

### design/vpi_checker.sv
// ----------------------------------------------------------------------------
// vpi_checker
// Port-level checks of the particle integrator, bound to the top level.
// ----------------------------------------------------------------------------
`include "verlet_particle_integrator_unit_defines.svh"

module vpi_checker
	import vpi_pkg::*;
#(
	parameter int PARTICLES = PARTICLES_DEF
) (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [9:0]         particle_out,
	input logic signed [31:0] pos_x,
	input logic signed [31:0] pos_y,
	input logic signed [31:0] heading,
	input logic signed [31:0] vel_x_out,
	input logic signed [31:0] vel_y_out,
	input logic signed [31:0] vel_a_out,
	input logic               wrap_fault
);

	// Hold a stalled result
	`VPI_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(particle_out) && $stable(pos_x) && $stable(pos_y) && $stable(heading) && $stable(vel_x_out) && $stable(vel_y_out) && $stable(vel_a_out) && $stable(wrap_fault), "result changed while stalled")

	// One request at a time: ready drops after an accepted request
	`VPI_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "request accepted while busy")

	// An absent particle reports zero state
	`VPI_ASSERT_SAME(a_absent_zero, out_valid && (int'(particle_out) >= PARTICLES), pos_x == 0 && pos_y == 0 && heading == 0 && vel_x_out == 0 && vel_y_out == 0 && vel_a_out == 0 && !wrap_fault, "absent particle reported state")

	// A wrap fault leaves the heading outside plus or minus pi
	`VPI_ASSERT_SAME(a_fault_heading, out_valid && wrap_fault, (heading > PI_Q) || (heading < -PI_Q), "wrap fault with heading in range")

endmodule

bind verlet_particle_integrator_unit vpi_checker #(.PARTICLES(PARTICLES)) u_vpi_checker (.*);

### bench/verlet_particle_integrator_unit_test.sv
// ----------------------------------------------------------------------------
// Particle integrator regression bench
// Drives step and load requests into the integrator under random handshake
// pressure and several register settings, and checks each result against its
// typed value or a cycle-free fixed-point predictor of the table kept on the side.
// ----------------------------------------------------------------------------
module verlet_particle_integrator_unit_test;
	import vpi_pkg::*;

	localparam int PARTICLES      = PARTICLES_DEF;
	localparam int SLOT_W         = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;
	localparam int HALF_PERIOD    = 5;
	localparam int RESET_CYCLES   = 9;
	localparam int LATENCY        = 5;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASES         = 7;
	localparam int PHASE_ITEMS    = 250;
	localparam int PRINT_CAP      = 200;

	localparam longint HALF_TURN = longint'(PI_Q);
	localparam longint FULL_TURN = longint'(TWO_PI_Q);

	localparam logic signed [31:0] TOP    = 32'sh7fffffff;
	localparam logic signed [31:0] BOTTOM = 32'sh80000000;
	localparam logic signed [31:0] NIL    = 32'sh00000000;
	localparam logic signed [31:0] ONES   = 32'shffffffff;

	typedef struct packed {
		logic [1:0]         func;
		logic [9:0]         particle;
		logic signed [31:0] fx;
		logic signed [31:0] fy;
		logic signed [31:0] fa;
	} request_t;

	typedef struct packed {
		logic [9:0]         particle;
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] hd;
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic signed [31:0] va;
		logic               fault;
	} snapshot_t;

	typedef struct packed {
		request_t  req;
		logic      typed;
		snapshot_t want;
	} row_t;

	localparam int DIRECTED_ROWS = 25;

	// Opening requests; typed rows carry their result, the rest use the predictor
	localparam row_t DIRECTED [DIRECTED_ROWS] = '{
		'{'{FUNC_STEP, 10'd0, NIL, NIL, NIL}, 1'b1,
			'{10'd0, NIL, NIL, NIL, NIL, NIL, NIL, 1'b0}},
		'{'{FUNC_STEP, 10'd1023, TOP, BOTTOM, TOP}, 1'b1,
			'{10'd1023, NIL, NIL, NIL, NIL, NIL, NIL, 1'b0}},
		'{'{FUNC_LOAD_POS, 10'd2, ONES, ONES, ONES}, 1'b1,
			'{10'd2, NIL, NIL, NIL, NIL, NIL, NIL, 1'b0}},
		'{'{FUNC_LOAD_POS, 10'd0, 32'sh00050000, 32'sh00030000, NIL}, 1'b1,
			'{10'd0, 32'sh00050000, 32'sh00030000, NIL, NIL, NIL, NIL, 1'b0}},
		'{'{FUNC_LOAD_VEL, 10'd0, TOP, BOTTOM, TOP}, 1'b1,
			'{10'd0, 32'sh00050000, 32'sh00030000, NIL, TOP, BOTTOM, TOP, 1'b0}},
		'{'{FUNC_LOAD_ACC, 10'd0, BOTTOM, TOP, BOTTOM}, 1'b1,
			'{10'd0, 32'sh00050000, 32'sh00030000, NIL, TOP, BOTTOM, TOP, 1'b0}},
		'{'{FUNC_STEP, 10'd0, TOP, BOTTOM, NIL}, 1'b0, '0},
		'{'{FUNC_STEP, 10'd0, NIL, NIL, NIL}, 1'b0, '0},
		'{'{FUNC_LOAD_POS, 10'd1, TOP, BOTTOM, BOTTOM}, 1'b1,
			'{10'd1, TOP, BOTTOM, BOTTOM, NIL, NIL, NIL, 1'b0}},
		'{'{FUNC_LOAD_VEL, 10'd1, TOP, BOTTOM, BOTTOM}, 1'b1,
			'{10'd1, TOP, BOTTOM, BOTTOM, TOP, BOTTOM, BOTTOM, 1'b0}},
		'{'{FUNC_STEP, 10'd1, NIL, NIL, NIL}, 1'b0, '0},
		'{'{FUNC_LOAD_VEL, 10'd1, 32'shffec0000, 32'sh00140000, 32'sh001e0000}, 1'b0, '0},
		'{'{FUNC_LOAD_ACC, 10'd1, NIL, NIL, NIL}, 1'b0, '0},
		'{'{FUNC_LOAD_POS, 10'd1, 32'sh00010000, 32'sh00050000, PI_Q}, 1'b0, '0},
		'{'{FUNC_STEP, 10'd1, 32'sh00010000, 32'shffff0000, 32'sh00010000}, 1'b0, '0},
		'{'{FUNC_LOAD_POS, 10'd1, NIL, 32'sh00060000, -PI_Q}, 1'b0, '0},
		'{'{FUNC_LOAD_VEL, 10'd1, 32'shffff0000, 32'sh00010000, 32'shffe20000}, 1'b0, '0},
		'{'{FUNC_STEP, 10'd1, NIL, NIL, NIL}, 1'b0, '0},
		'{'{FUNC_LOAD_VEL, 10'd512, TOP, TOP, TOP}, 1'b1,
			'{10'd512, NIL, NIL, NIL, NIL, NIL, NIL, 1'b0}},
		'{'{FUNC_LOAD_ACC, 10'd1022, BOTTOM, BOTTOM, BOTTOM}, 1'b1,
			'{10'd1022, NIL, NIL, NIL, NIL, NIL, NIL, 1'b0}},
		'{'{FUNC_STEP, 10'd3, ONES, TOP, BOTTOM}, 1'b1,
			'{10'd3, NIL, NIL, NIL, NIL, NIL, NIL, 1'b0}},
		'{'{FUNC_LOAD_POS, 10'd0, 32'sh000a0000, NIL, TOP}, 1'b0, '0},
		'{'{FUNC_STEP, 10'd0, BOTTOM, TOP, TOP}, 1'b0, '0},
		'{'{FUNC_LOAD_ACC, 10'd1, TOP, TOP, TOP}, 1'b0, '0},
		'{'{FUNC_STEP, 10'd1, BOTTOM, BOTTOM, BOTTOM}, 1'b0, '0}
	};

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_wr_en;
	logic [1:0]         cfg_index;
	logic [15:0]        cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic [1:0]         func;
	logic [9:0]         particle;
	logic signed [31:0] value_x;
	logic signed [31:0] value_y;
	logic signed [31:0] value_a;
	logic               out_valid;
	logic               out_ready;
	logic [9:0]         particle_out;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] heading;
	logic signed [31:0] vel_x_out;
	logic signed [31:0] vel_y_out;
	logic signed [31:0] vel_a_out;
	logic               wrap_fault;

	// Predicted particle table and register copies
	logic signed [31:0] cur_x [PARTICLES];
	logic signed [31:0] cur_y [PARTICLES];
	logic signed [31:0] cur_heading [PARTICLES];
	logic signed [31:0] cur_vel [PARTICLES][3];
	logic signed [31:0] cur_acc [PARTICLES][3];
	logic [15:0]        step_dt;
	logic [14:0]        wall_x;
	logic [14:0]        wall_y;

	snapshot_t predicted_states [$];
	snapshot_t front_state;
	int        mismatches    = 0;
	int        requests_sent = 0;
	int        quiet_cycles  = 0;
	int        stall_left    = 0;
	bit        calm          = 1'b0;

	verlet_particle_integrator_unit #(.PARTICLES(PARTICLES)) i_dut (.*);

	always #(HALF_PERIOD) clk = ~clk;

	// Clamp to the signed 32-bit range
	function automatic logic signed [31:0] clamp32(input longint v);
		if (v > 64'sd2147483647) begin
			return TOP;
		end else if (v < -64'sd2147483648) begin
			return BOTTOM;
		end
		return v[31:0];
	endfunction

	// Rounded displacement v*dt + a*dt*dt/2 in Q16.16
	function automatic longint drift(input logic signed [31:0] vel, input logic signed [31:0] acc,
			input longint dt);
		longint sum;
		sum = longint'(vel) * dt + ((longint'(acc) * (dt * dt)) >>> 17);
		return (sum + 64'sd32768) >>> 16;
	endfunction

	// Reflect once off the wall at zero or at the room size, flip the velocity
	function automatic void bounce(inout logic signed [31:0] pos, inout logic signed [31:0] vel,
			input longint p, input logic [14:0] bound);
		longint limit;
		limit = longint'(bound) * 64'sd65536;
		if (p < 0) begin
			p = -p;
			vel = clamp32(-longint'(vel));
		end else if (p > limit) begin
			p = 2 * limit - p;
			vel = clamp32(-longint'(vel));
		end
		pos = clamp32(p);
	endfunction

	// Apply one request to the predicted table and return the particle state
	function automatic snapshot_t integrate_particle(input request_t r);
		snapshot_t          s;
		logic [SLOT_W-1:0]  slot;
		logic signed [31:0] applied [3];
		longint             dt;
		longint             nx;
		longint             ny;
		longint             na;
		longint             inc;
		logic               fault;
		s = '0;
		s.particle = r.particle;
		if (int'(r.particle) >= PARTICLES) begin
			return s;
		end
		slot = r.particle[SLOT_W-1:0];
		applied[0] = r.fx;
		applied[1] = r.fy;
		applied[2] = r.fa;
		fault = 1'b0;
		case (r.func)
			FUNC_STEP: begin
				dt = longint'(step_dt);
				nx = longint'(cur_x[slot]) + drift(cur_vel[slot][0], cur_acc[slot][0], dt);
				ny = longint'(cur_y[slot]) + drift(cur_vel[slot][1], cur_acc[slot][1], dt);
				na = longint'(cur_heading[slot]) + drift(cur_vel[slot][2], cur_acc[slot][2], dt);
				bounce(cur_x[slot], cur_vel[slot][0], nx, wall_x);
				bounce(cur_y[slot], cur_vel[slot][1], ny, wall_y);
				// one turn of correction toward plus or minus pi
				if (na > HALF_TURN) begin
					na = na - FULL_TURN;
				end else if (na < -HALF_TURN) begin
					na = na + FULL_TURN;
				end
				fault = (na > HALF_TURN) || (na < -HALF_TURN);
				cur_heading[slot] = clamp32(na);
				for (int j = 0; j < 3; j++) begin
					inc = ((longint'(cur_acc[slot][j]) + longint'(applied[j])) * dt
						+ 64'sd65536) >>> 17;
					cur_vel[slot][j] = clamp32(longint'(cur_vel[slot][j]) + inc);
					cur_acc[slot][j] = applied[j];
				end
			end
			FUNC_LOAD_POS: begin
				cur_x[slot] = r.fx;
				cur_y[slot] = r.fy;
				cur_heading[slot] = r.fa;
			end
			FUNC_LOAD_VEL: begin
				for (int j = 0; j < 3; j++) cur_vel[slot][j] = applied[j];
			end
			FUNC_LOAD_ACC: begin
				for (int j = 0; j < 3; j++) cur_acc[slot][j] = applied[j];
			end
			default: ;
		endcase
		s.px = cur_x[slot];
		s.py = cur_y[slot];
		s.hd = cur_heading[slot];
		s.vx = cur_vel[slot][0];
		s.vy = cur_vel[slot][1];
		s.va = cur_vel[slot][2];
		s.fault = fault;
		return s;
	endfunction

	// Append a prediction behind the ones still outstanding
	function automatic void enqueue_state(input snapshot_t s);
		predicted_states.insert(predicted_states.size(), s);
	endfunction

	// Log-uniform magnitudes with a share of extremes and raw words
	function automatic logic signed [31:0] rand_word();
		logic [31:0] mag;
		int unsigned bits;
		case ($urandom_range(0, 15))
			0: return TOP;
			1: return BOTTOM;
			2: return NIL;
			3, 4: return $urandom;
			default: begin
				bits = $urandom_range(1, 31);
				mag = $urandom >> (32 - bits);
				return ($urandom_range(0, 1) != 0) ? -$signed(mag) : $signed(mag);
			end
		endcase
	endfunction

	// Coordinate inside the room, now and then anywhere
	function automatic logic signed [31:0] place(input logic [14:0] bound);
		if ($urandom_range(0, 7) == 0) begin
			return $urandom;
		end
		return $urandom_range(0, {1'b0, bound, 16'h0000});
	endfunction

	function automatic void compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= PRINT_CAP) begin
				$display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
			end
		end
	endfunction

	// Drop the request valid for a number of cycles
	task automatic hold_requests(input int cycles);
		repeat (cycles) begin
			@(negedge clk);
			in_valid = 1'b0;
		end
	endtask

	// Hold requests until every predicted result is back, then wait on
	task automatic drain_results(input int extra);
		hold_requests(1);
		while (predicted_states.size() != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_register(input logic [1:0] index, input logic [15:0] data);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_index = index;
		cfg_data = data;
		@(posedge clk);
		case (index)
			REG_TIME_STEP:   step_dt = data;
			REG_ROOM_LENGTH: wall_x = data[14:0];
			REG_ROOM_WIDTH:  wall_y = data[14:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	// Present one request, wait for acceptance and record its result
	task automatic issue(input request_t r, input bit typed = 1'b0, input snapshot_t want = '0);
		snapshot_t predicted;
		@(negedge clk);
		func = r.func;
		particle = r.particle;
		value_x = r.fx;
		value_y = r.fy;
		value_a = r.fa;
		in_valid = 1'b1;
		@(posedge clk);
		while (in_ready !== 1'b1) @(posedge clk);
		predicted = integrate_particle(r);
		enqueue_state(typed ? want : predicted);
		if (int'(r.particle) < PARTICLES) begin
			requests_sent++;
		end
		if (!calm && $urandom_range(0, 3) == 0) begin
			hold_requests(int'($urandom_range(1, 3)));
		end
	endtask

	// Stall the result side in short bursts
	always @(negedge clk) begin
		if (calm) begin
			out_ready = 1'b1;
		end else if (stall_left != 0) begin
			out_ready = 1'b0;
			stall_left--;
		end else if ($urandom_range(0, 4) == 0) begin
			out_ready = 1'b0;
			stall_left = int'($urandom_range(0, 2));
		end else begin
			out_ready = 1'b1;
		end
	end

	// Check each accepted result against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (predicted_states.size() == 0) begin
				mismatches++;
				if (mismatches <= PRINT_CAP) begin
					$display("%0t: result mismatch: expected none, got particle %0d",
						$time, particle_out);
				end
			end else begin
				front_state = predicted_states.pop_front();
				compare_field("particle_out", 32'(front_state.particle), 32'(particle_out));
				compare_field("pos_x", front_state.px, pos_x);
				compare_field("pos_y", front_state.py, pos_y);
				compare_field("heading", front_state.hd, heading);
				compare_field("vel_x_out", front_state.vx, vel_x_out);
				compare_field("vel_y_out", front_state.vy, vel_y_out);
				compare_field("vel_a_out", front_state.va, vel_a_out);
				compare_field("wrap_fault", 32'(front_state.fault), 32'(wrap_fault));
			end
		end
	end

	// End the run when neither channel moves for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("verlet_particle_integrator_unit regression: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		request_t    r;
		logic [9:0]  target;
		logic [15:0] dt_new;
		logic [15:0] len_new;
		logic [15:0] wid_new;
		int          phase_start;
		int          steps;
		int          sequences;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_TIME_STEP;
		cfg_data = '0;
		in_valid = 1'b0;
		func = FUNC_STEP;
		particle = '0;
		value_x = '0;
		value_y = '0;
		value_a = '0;
		out_ready = 1'b0;
		step_dt = TIME_STEP_RESET;
		wall_x = ROOM_LENGTH_RESET;
		wall_y = ROOM_WIDTH_RESET;
		foreach (cur_x[i]) begin
			cur_x[i] = '0;
			cur_y[i] = '0;
			cur_heading[i] = '0;
			for (int j = 0; j < 3; j++) begin
				cur_vel[i][j] = '0;
				cur_acc[i][j] = '0;
			end
		end
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed requests at the reset settings
		foreach (DIRECTED[n]) begin
			issue(DIRECTED[n].req, DIRECTED[n].typed, DIRECTED[n].want);
		end

		sequences = 0;
		for (int phase = 0; phase < PHASES; phase++) begin
			drain_results(2 * LATENCY);
			case (phase)
				0: begin
					dt_new = 16'hffff;
					len_new = 16'hffff;
					wid_new = 16'hffff;
				end
				1: begin
					dt_new = 16'hffff;
					len_new = 16'd10;
					wid_new = 16'd6;
				end
				2: begin
					dt_new = 16'd1;
					len_new = 16'd1;
					wid_new = 16'd1;
				end
				3: begin
					dt_new = 16'd0;
					len_new = 16'd0;
					wid_new = 16'd0;
				end
				PHASES - 1: begin
					dt_new = TIME_STEP_RESET;
					len_new = 16'(ROOM_LENGTH_RESET);
					wid_new = 16'(ROOM_WIDTH_RESET);
				end
				default: begin
					dt_new = 16'($urandom_range(0, 65535));
					len_new = 16'($urandom_range(0, 65535));
					wid_new = 16'($urandom_range(0, 65535));
				end
			endcase
			write_register(REG_TIME_STEP, dt_new);
			write_register(REG_ROOM_LENGTH, len_new);
			write_register(REG_ROOM_WIDTH, wid_new);

			phase_start = requests_sent;
			while (requests_sent - phase_start < PHASE_ITEMS) begin
				sequences++;
				calm = (phase == PHASES - 1) || ($urandom_range(0, 3) == 0);
				// let the pipeline run dry now and then
				if (sequences % 40 == 17) begin
					drain_results(0);
				end
				if ($urandom_range(0, 4) == 0) begin
					// noise request: any function, any index, any payload
					r.func = 2'($urandom_range(0, 3));
					r.particle = 10'($urandom_range(0, 1023));
					r.fx = $urandom;
					r.fy = $urandom;
					r.fa = $urandom;
					issue(r);
				end else begin
					// load some state, then advance the same particle a few steps
					target = 10'($urandom_range(0, PARTICLES - 1));
					if ($urandom_range(0, 3) != 0) begin
						r.func = FUNC_LOAD_POS;
						r.particle = target;
						r.fx = place(wall_x);
						r.fy = place(wall_y);
						r.fa = ($urandom_range(0, 7) == 0) ? rand_word()
							: $signed($urandom_range(0, TWO_PI_Q)) - PI_Q;
						issue(r);
					end
					if ($urandom_range(0, 3) != 0) begin
						r = '{FUNC_LOAD_VEL, target, rand_word(), rand_word(), rand_word()};
						issue(r);
					end
					if ($urandom_range(0, 2) != 0) begin
						r = '{FUNC_LOAD_ACC, target, rand_word(), rand_word(), rand_word()};
						issue(r);
					end
					steps = int'($urandom_range(1, 8));
					repeat (steps) begin
						r = '{FUNC_STEP, target, rand_word(), rand_word(), rand_word()};
						issue(r);
					end
				end
			end
		end

		drain_results(4 * LATENCY);
		if (mismatches == 0) begin
			$display("verlet_particle_integrator_unit regression: pass");
		end else begin
			$display("verlet_particle_integrator_unit regression: fail");
		end
		$finish;
	end

endmodule
